// ===== sv/afr_pkg.sv =====
// Shared types and constants for the addressed frame receiver.
// Holds the request and response word structs, frame position codes and
// configuration register indexes. No dependencies.
package afr_pkg;

   localparam int ByteW   = 8;
   localparam int NibbleW = 4;
   localparam int PosW    = 5;
   localparam int CsrIdxW = 2;

   // Longest frame: marker, address, length/command, payload, checksum.
   localparam int MaxFrameDefault = 19;

   // Frame position codes.
   localparam logic [PosW-1:0] PosHunt    = 5'd0;
   localparam logic [PosW-1:0] PosAddr    = 5'd1;
   localparam logic [PosW-1:0] PosLen     = 5'd2;
   localparam logic [PosW-1:0] PosPayload = 5'd3;

   // Bytes of a frame that are not payload.
   localparam logic [PosW-1:0] FrameOverhead = 5'd4;

   typedef enum logic [CsrIdxW-1:0] {
      CsrModuleAddress = 2'd0,
      CsrGroupAddress  = 2'd1,
      CsrGroupLeader   = 2'd2,
      CsrStartMarker   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [ByteW-1:0] rx_byte;
      logic             chain_in_active;
   } req_payload_type;

   typedef struct packed {
      logic [NibbleW-1:0] command_code;
      logic               checksum_ok;
      logic               report_status;
      logic [ByteW-1:0]   payload_byte;
      logic               payload_valid;
      logic               last_item;
   } rsp_payload_type;

endpackage

// ===== sv/addressed_frame_receiver.sv =====
// Addressed frame receiver: frame parser, payload banks and response run.
// Depends on afr_pkg for word structs, position codes and register indexes.
//
// Takes one received byte per cycle, also while hunting for the marker and for
// dropped bytes, and frames packets of the form marker, address, length/command,
// payload, additive checksum. When the checksum byte of an addressed frame
// arrives, the payload goes out as a run of one response word per cycle
// while rsp_ready is high (a single word for an empty payload), read
// from one of two payload banks, so the next frame fills the other bank while
// the run drains. The first word of a run is presented the cycle after the
// checksum byte is taken. Any byte that arrives at the checksum position,
// including one dropped under the chain pin, waits at the request port while
// the previous run is still being drained, and is taken no earlier than the
// cycle after the last word of that run is taken; all other bytes are taken
// at once. Payload banks need no clearing pass and are usable right after reset.
module addressed_frame_receiver #(
   parameter int MAX_FRAME = afr_pkg::MaxFrameDefault
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  afr_pkg::req_payload_type        req_data,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output afr_pkg::rsp_payload_type        rsp_data,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [afr_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [afr_pkg::ByteW-1:0]       csr_data
);

   localparam int StoreDepth = (MAX_FRAME > 5) ? (MAX_FRAME - 4) : 1;
   localparam int IdxW       = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
   localparam logic [afr_pkg::PosW-1:0] MaxFrameCode = afr_pkg::PosW'(MAX_FRAME);

   // Configuration registers
   logic [afr_pkg::ByteW-1:0] module_address_ff;
   logic [afr_pkg::ByteW-1:0] group_address_ff;
   logic                      group_leader_ff;
   logic [afr_pkg::ByteW-1:0] start_marker_ff;

   // Parser state
   logic [afr_pkg::PosW-1:0]  pos_ff, pos_in;
   logic [afr_pkg::PosW-1:0]  total_ff, total_in;
   logic [afr_pkg::ByteW-1:0] addr_ff, addr_in;
   logic [afr_pkg::ByteW-1:0] lencmd_ff, lencmd_in;
   logic [afr_pkg::ByteW-1:0] sum_ff, sum_in;
   logic                      wr_bank_ff, wr_bank_in;

   // Payload banks
   logic [afr_pkg::ByteW-1:0] store_ff [2][StoreDepth];

   // Response run
   logic                        run_busy_ff, run_busy_in;
   logic                        run_bank_ff, run_bank_in;
   logic [afr_pkg::NibbleW-1:0] run_idx_ff, run_idx_in;
   logic [afr_pkg::NibbleW-1:0] run_last_ff, run_last_in;
   logic                        run_nonempty_ff, run_nonempty_in;
   logic [afr_pkg::NibbleW-1:0] run_cmd_ff, run_cmd_in;
   logic                        run_ok_ff, run_ok_in;
   logic                        run_sreq_ff, run_sreq_in;

   logic                        req_fire;
   logic                        rsp_fire;
   logic                        chain_hold;
   logic                        in_payload;
   logic                        frame_done;
   logic                        store_we;
   logic [afr_pkg::PosW-1:0]    store_pos;
   logic [IdxW-1:0]             store_idx;
   logic [afr_pkg::ByteW-1:0]   c;
   logic [afr_pkg::NibbleW-1:0] len_n;
   logic [afr_pkg::ByteW-1:0]   rd_byte;

   assign c          = req_data.rx_byte;
   assign req_fire   = req_valid && req_ready;
   assign rsp_fire   = rsp_valid && rsp_ready;
   assign chain_hold = req_data.chain_in_active && (module_address_ff == '0);
   assign in_payload = (pos_ff >= afr_pkg::PosPayload);
   assign frame_done = in_payload &&
                       (({1'b0, pos_ff} + 6'd1) >= {1'b0, total_ff});
   assign store_pos  = pos_ff - afr_pkg::PosPayload;
   assign store_idx  = store_pos[IdxW-1:0];
   assign len_n      = lencmd_ff[afr_pkg::ByteW-1 -: afr_pkg::NibbleW];

   // Hold the checksum byte until the previous run has drained.
   assign req_ready = !(run_busy_ff && frame_done);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         module_address_ff <= '0;
         group_address_ff  <= '1;
         group_leader_ff   <= 1'b0;
         start_marker_ff   <= '0;
      end else if (csr_valid) begin
         unique case (afr_pkg::csr_index_type'(csr_index))
            afr_pkg::CsrModuleAddress: module_address_ff <= csr_data;
            afr_pkg::CsrGroupAddress:  group_address_ff  <= csr_data;
            afr_pkg::CsrGroupLeader:   group_leader_ff   <= csr_data[0];
            afr_pkg::CsrStartMarker:   start_marker_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Parser and response run next state
   always_comb begin
      pos_in          = pos_ff;
      total_in        = total_ff;
      addr_in         = addr_ff;
      lencmd_in       = lencmd_ff;
      sum_in          = sum_ff;
      wr_bank_in      = wr_bank_ff;
      store_we        = 1'b0;
      run_busy_in     = run_busy_ff;
      run_bank_in     = run_bank_ff;
      run_idx_in      = run_idx_ff;
      run_last_in     = run_last_ff;
      run_nonempty_in = run_nonempty_ff;
      run_cmd_in      = run_cmd_ff;
      run_ok_in       = run_ok_ff;
      run_sreq_in     = run_sreq_ff;

      // Advance the run on each taken word; drop busy after the last one.
      if (rsp_fire) begin
         if (run_idx_ff == run_last_ff) begin
            run_busy_in = 1'b0;
         end else begin
            run_idx_in = run_idx_ff + 1'b1;
         end
      end

      if (req_fire && !chain_hold) begin
         unique case (pos_ff)
            afr_pkg::PosHunt: begin
               if (c == start_marker_ff) begin
                  pos_in = afr_pkg::PosAddr;
               end
            end
            afr_pkg::PosAddr: begin
               if (c == module_address_ff || c == group_address_ff) begin
                  addr_in = c;
                  sum_in  = c;
                  pos_in  = afr_pkg::PosLen;
               end else begin
                  pos_in = afr_pkg::PosHunt;
               end
            end
            afr_pkg::PosLen: begin
               lencmd_in = c;
               sum_in    = sum_ff + c;
               total_in  = {1'b0, c[afr_pkg::ByteW-1 -: afr_pkg::NibbleW]}
                           + afr_pkg::FrameOverhead;
               if (total_in > MaxFrameCode) begin
                  pos_in = afr_pkg::PosHunt;
               end else begin
                  pos_in = afr_pkg::PosPayload;
               end
            end
            default: begin
               if (frame_done) begin
                  // Hand the filled bank to the run, fill the other one next.
                  pos_in          = afr_pkg::PosHunt;
                  run_busy_in     = 1'b1;
                  run_bank_in     = wr_bank_ff;
                  wr_bank_in      = !wr_bank_ff;
                  run_idx_in      = '0;
                  run_nonempty_in = (len_n != '0);
                  run_last_in     = (len_n != '0) ? len_n - 1'b1 : '0;
                  run_cmd_in      = lencmd_ff[afr_pkg::NibbleW-1:0];
                  run_ok_in       = (sum_ff == c);
                  run_sreq_in     = (addr_ff == module_address_ff) || group_leader_ff;
               end else begin
                  store_we = (store_pos < afr_pkg::PosW'(StoreDepth));
                  sum_in   = sum_ff + c;
                  pos_in   = pos_ff + 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= afr_pkg::PosHunt;
         total_ff    <= '0;
         addr_ff     <= '0;
         lencmd_ff   <= '0;
         sum_ff      <= '0;
         wr_bank_ff  <= 1'b0;
         run_busy_ff <= 1'b0;
         run_bank_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         total_ff    <= total_in;
         addr_ff     <= addr_in;
         lencmd_ff   <= lencmd_in;
         sum_ff      <= sum_in;
         wr_bank_ff  <= wr_bank_in;
         run_busy_ff <= run_busy_in;
         run_bank_ff <= run_bank_in;
      end
   end

   always_ff @(posedge clock) begin
      run_idx_ff      <= run_idx_in;
      run_last_ff     <= run_last_in;
      run_nonempty_ff <= run_nonempty_in;
      run_cmd_ff      <= run_cmd_in;
      run_ok_ff       <= run_ok_in;
      run_sreq_ff     <= run_sreq_in;
      if (store_we) begin
         store_ff[wr_bank_ff][store_idx] <= c;
      end
   end

   assign rd_byte = store_ff[run_bank_ff][run_idx_ff[IdxW-1:0]];

   always_comb begin
      rsp_data               = '0;
      rsp_data.command_code  = run_cmd_ff;
      rsp_data.checksum_ok   = run_ok_ff;
      rsp_data.report_status = run_sreq_ff;
      rsp_data.payload_byte  = run_nonempty_ff ? rd_byte : '0;
      rsp_data.payload_valid = run_nonempty_ff;
      rsp_data.last_item     = (run_idx_ff == run_last_ff);
   end

   assign rsp_valid = run_busy_ff;

   // The run never reads the bank that the parser is filling.
   a_bank_split: assert property (@(posedge clock) disable iff (reset)
      run_busy_ff |-> (wr_bank_ff != run_bank_ff))
      else $error("run bank and fill bank coincide");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_busy_ff |-> (run_idx_ff <= run_last_ff))
      else $error("run index past last item");

   a_run_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !chain_hold && frame_done) |=> (run_busy_ff && run_idx_ff == '0))
      else $error("completed frame did not start a run");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_data.last_item) |=> !run_busy_ff)
      else $error("run still busy after last word");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff < MaxFrameCode)
      else $error("frame position beyond longest frame");

endmodule
